>>> rtl/idte_pkg.sv
// shared types and constants for the datetime to epoch converter
`default_nettype none
package idte_pkg;

  typedef enum logic [4:0] {
    PH_YEAR, PH_DASH1, PH_MONTH, PH_DASH2, PH_DAY, PH_DATE_END, PH_HOUR, PH_COLON,
    PH_MINUTE, PH_AFTER_MIN, PH_SECOND, PH_AFTER_SEC, PH_FRAC_ONE, PH_FRAC_MORE,
    PH_OFF_HOUR, PH_OFF_COLON, PH_OFF_MIN, PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    ST_PARSE, ST_CONV0, ST_CONV1, ST_CONV2, ST_CONV3, ST_OUT
  } ctl_state_t;

  typedef struct packed {
    logic take;
    logic clear;
    logic [2:0] step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic end_ok;
  } stat_t;

  localparam logic [7:0] CH_0 = 8'd48;
  localparam logic [7:0] CH_9 = 8'd57;

endpackage
`default_nettype wire

>>> rtl/idte_datapath.sv
// field accumulation and epoch arithmetic
`default_nettype none
module idte_datapath (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic [7:0] c,
  input  wire idte_pkg::cmd_t cmd,
  output idte_pkg::stat_t stat,
  output logic parse_ok_r,
  output logic signed [62:0] epoch_r
);
  import idte_pkg::*;

  phase_t phase, phase_next;
  logic [3:0] dig, dig_next;
  logic [13:0] yr, yr_next;
  logic [6:0] mo, dy, hr, mi, se, oh, om;
  logic [6:0] mo_next, dy_next, hr_next, mi_next, se_next, oh_next, om_next;
  logic [29:0] fr, fr_next;
  logic [3:0] fd, fd_next;
  logic oneg, oneg_next, err, err_next;

  logic isd;
  logic [3:0] dv;
  assign isd = (c >= CH_0) && (c <= CH_9);
  assign dv = 4'(c - CH_0);

  // day of the march-based year on which each month starts
  function automatic logic [8:0] month_start(input logic [3:0] m);
    case (m)
      4'd0:    month_start = 9'd0;
      4'd1:    month_start = 9'd31;
      4'd2:    month_start = 9'd61;
      4'd3:    month_start = 9'd92;
      4'd4:    month_start = 9'd122;
      4'd5:    month_start = 9'd153;
      4'd6:    month_start = 9'd184;
      4'd7:    month_start = 9'd214;
      4'd8:    month_start = 9'd245;
      4'd9:    month_start = 9'd275;
      4'd10:   month_start = 9'd306;
      4'd11:   month_start = 9'd337;
      default: month_start = 9'd0;
    endcase
  endfunction

  always_comb begin
    phase_next = phase; dig_next = dig; yr_next = yr; mo_next = mo; dy_next = dy;
    hr_next = hr; mi_next = mi; se_next = se; oh_next = oh; om_next = om;
    fr_next = fr; fd_next = fd; oneg_next = oneg; err_next = err;
    if (!err) begin
      case (phase)
        PH_YEAR, PH_MONTH, PH_DAY, PH_HOUR, PH_MINUTE, PH_SECOND, PH_OFF_HOUR,
        PH_OFF_MIN: begin
          if (!isd) err_next = 1'b1;
          else begin
            case (phase)
              PH_YEAR:     yr_next = 14'(yr * 10 + dv);
              PH_MONTH:    mo_next = 7'(mo * 10 + dv);
              PH_DAY:      dy_next = 7'(dy * 10 + dv);
              PH_HOUR:     hr_next = 7'(hr * 10 + dv);
              PH_MINUTE:   mi_next = 7'(mi * 10 + dv);
              PH_SECOND:   se_next = 7'(se * 10 + dv);
              PH_OFF_HOUR: oh_next = 7'(oh * 10 + dv);
              default:     om_next = 7'(om * 10 + dv);
            endcase
            dig_next = dig + 4'd1;
            if (dig_next >= ((phase == PH_YEAR) ? 4'd4 : 4'd2)) begin
              dig_next = '0;
              case (phase)
                PH_YEAR:     phase_next = PH_DASH1;
                PH_MONTH:    phase_next = PH_DASH2;
                PH_DAY:      phase_next = PH_DATE_END;
                PH_HOUR:     phase_next = PH_COLON;
                PH_MINUTE:   phase_next = PH_AFTER_MIN;
                PH_SECOND:   phase_next = PH_AFTER_SEC;
                PH_OFF_HOUR: phase_next = PH_OFF_COLON;
                default:     phase_next = PH_DONE;
              endcase
            end
          end
        end
        PH_DASH1: if (c == "-") phase_next = PH_MONTH; else err_next = 1'b1;
        PH_DASH2: if (c == "-") phase_next = PH_DAY; else err_next = 1'b1;
        PH_DATE_END: if (c == "T" || c == " ") phase_next = PH_HOUR; else err_next = 1'b1;
        PH_COLON: if (c == ":") phase_next = PH_MINUTE; else err_next = 1'b1;
        PH_OFF_COLON: if (c == ":") phase_next = PH_OFF_MIN; else err_next = 1'b1;
        PH_AFTER_MIN, PH_AFTER_SEC, PH_FRAC_ONE, PH_FRAC_MORE: begin
          if ((phase == PH_FRAC_ONE || phase == PH_FRAC_MORE) && isd) begin
            if (fd < 4'd9) begin
              fr_next = 30'(fr * 10 + dv);
              fd_next = fd + 4'd1;
            end
            phase_next = PH_FRAC_MORE;
          end else if (phase == PH_AFTER_MIN && c == ":") phase_next = PH_SECOND;
          else if (phase == PH_FRAC_ONE) err_next = 1'b1;
          else if (c == "." && phase != PH_FRAC_MORE) phase_next = PH_FRAC_ONE;
          else if (c == "Z" || c == "z") phase_next = PH_DONE;
          else if (c == "+" || c == "-") begin
            oneg_next = (c == "-");
            phase_next = PH_OFF_HOUR;
          end else err_next = 1'b1;
        end
        default: err_next = 1'b1;
      endcase
    end
  end

  // range checks on the next-state fields
  logic leap, fv, end_ph;
  logic [4:0] maxd;
  always_comb begin
    // within 1970..2100 only 2100 is a multiple of four that is not leap
    leap = (yr_next[1:0] == 2'b00) && (yr_next != 14'd2100);
    case (mo_next)
      7'd2:    maxd = leap ? 5'd29 : 5'd28;
      7'd4, 7'd6, 7'd9, 7'd11: maxd = 5'd30;
      default: maxd = 5'd31;
    endcase
    fv = (yr_next >= 14'd1970) && (yr_next <= 14'd2100) && (mo_next >= 7'd1) &&
         (mo_next <= 7'd12) && (dy_next >= 7'd1) && (dy_next <= 7'(maxd)) &&
         (hr_next <= 7'd23) && (mi_next <= 7'd59) && (se_next <= 7'd60) &&
         (oh_next <= 7'd23) && (om_next <= 7'd59);
    end_ph = (phase_next == PH_DATE_END) || (phase_next == PH_AFTER_MIN) ||
             (phase_next == PH_AFTER_SEC) || (phase_next == PH_FRAC_MORE) ||
             (phase_next == PH_DONE);
  end
  assign stat.end_ok = !err_next && end_ph && fv;

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      phase <= PH_YEAR; dig <= '0; yr <= '0; mo <= '0; dy <= '0; hr <= '0; mi <= '0;
      se <= '0; oh <= '0; om <= '0; fr <= '0; fd <= '0; oneg <= 1'b0; err <= 1'b0;
    end else if (cmd.take) begin
      phase <= phase_next; dig <= dig_next; yr <= yr_next; mo <= mo_next; dy <= dy_next;
      hr <= hr_next; mi <= mi_next; se <= se_next; oh <= oh_next; om <= om_next;
      fr <= fr_next; fd <= fd_next; oneg <= oneg_next; err <= err_next;
    end
  end

  // conversion: latched copy, then several multiply steps
  logic ok_l;
  logic [13:0] yy;
  logic [3:0] mp;
  logic [8:0] doy;
  logic signed [18:0] secod;
  logic [29:0] frs;
  logic [16:0] days;
  logic signed [37:0] sec;
  logic signed [62:0] ns_hi, ns_sum;
  logic [8:0] yoe;
  logic [29:0] f10;
  logic [3:0] fk;
  logic [2:0] cent;
  logic q400;

  assign q400 = (yoe >= 9'd400);
  assign cent = (yoe >= 9'd500) ? 3'd5 : (q400 ? 3'd4 : 3'd3);

  always_ff @(posedge clk) begin
    case (cmd.step)
      3'd1: begin
        ok_l  <= stat.end_ok;
        yy    <= (mo_next <= 7'd2) ? yr_next - 14'd1 : yr_next;
        mp    <= (mo_next > 7'd2) ? 4'(mo_next - 7'd3) : 4'(mo_next + 7'd9);
        doy   <= 9'(dy_next) - 9'd1;
        secod <= 19'(hr_next * 3600 + mi_next * 60 + se_next) -
                 (oneg_next ? -19'(oh_next * 3600 + om_next * 60)
                            : 19'(oh_next * 3600 + om_next * 60));
        frs   <= fr_next;
        fk    <= fd_next;
      end
      3'd2: begin
        yoe <= 9'(yy - 14'd1600);
        doy <= month_start(mp) + doy;
        if (fk < 4'd9) begin frs <= 30'(frs * 10); fk <= fk + 4'd1; end
      end
      3'd3: begin
        // days from the 1600 era base, moved to the epoch
        days <= 17'(32'(yoe) * 32'd365 + 32'(yoe[8:2]) - 32'(cent) + 32'(q400) +
                    32'(doy) - 32'd135080);
        if (fk < 4'd9) begin frs <= 30'(frs * 10); fk <= fk + 4'd1; end
      end
      3'd4: begin
        sec <= $signed({21'd0, days}) * 38'sd86400 + 38'(secod);
        if (fk < 4'd9) begin frs <= 30'(frs * 10); fk <= fk + 4'd1; end
      end
      3'd5: begin
        ns_hi <= 63'(sec * 64'sd1000000000);
        if (fk < 4'd9) begin frs <= 30'(frs * 10); fk <= fk + 4'd1; end
      end
      default: begin
        if (fk < 4'd9) begin frs <= 30'(frs * 10); fk <= fk + 4'd1; end
      end
    endcase
  end
  assign f10 = frs;
  assign ns_sum = ns_hi + 63'(f10);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      parse_ok_r <= ok_l;
      epoch_r <= ok_l ? ns_sum : '0;
    end
  end
endmodule
`default_nettype wire

>>> rtl/idte_ctrl.sv
// sequencing controller and output handshake
`default_nettype none
module idte_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic last_in,
  output logic in_ready,
  output logic out_valid,
  input  wire logic out_ready,
  output idte_pkg::cmd_t cmd
);
  import idte_pkg::*;

  ctl_state_t st, st_next;
  logic [3:0] cnt, cnt_next;
  logic ov, ov_next;

  always_comb begin
    st_next = st; cnt_next = cnt; ov_next = ov;
    if (ov && out_ready) ov_next = 1'b0;
    case (st)
      ST_PARSE: if (in_valid && last_in) begin st_next = ST_CONV0; cnt_next = 4'd2; end
      ST_CONV0: begin
        cnt_next = cnt + 4'd1;
        if (cnt == 4'd11) st_next = ST_OUT;
      end
      ST_OUT: if (!ov || out_ready) begin st_next = ST_PARSE; ov_next = 1'b1; end
      default: st_next = ST_PARSE;
    endcase
  end

  always_comb begin
    in_ready = (st == ST_PARSE);
    cmd.take = in_ready && in_valid;
    cmd.clear = (st == ST_PARSE) && in_valid && last_in;
    cmd.step = (st == ST_PARSE) ? ((in_valid && last_in) ? 3'd1 : 3'd0)
             : (st == ST_CONV0) ? ((cnt > 4'd5) ? 3'd6 : 3'(cnt)) : 3'd6;
    cmd.load_out = (st == ST_OUT) && (!ov || out_ready);
  end
  assign out_valid = ov;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_PARSE; cnt <= '0; ov <= 1'b0;
    end else begin
      st <= st_next; cnt <= cnt_next; ov <= ov_next;
    end
  end
endmodule
`default_nettype wire

>>> rtl/iso_datetime_to_epoch_ns.sv
// top level: iso datetime text to epoch nanoseconds
// usage:
//   input channel: char_code and last_char with in_valid / in_ready, one
//   character per item, one item per cycle while a text is being read.
//   output channel: parse_ok and epoch_ns with out_valid / out_ready, one
//   item per text, given after the item marked last_char.
//   sequence: once the last character is taken the text is converted
//   (fraction scaling by ten one step a cycle, day count, and the seconds
//   and nanosecond multiplies), then the result is registered and
//   out_valid rises.
//   throughput: one character per cycle, then in_ready is low while each
//   text is converted and its result registered.
//   the result register holds the item until taken; while the previous
//   result still waits the next text may already be read, and the new
//   result waits for the old one to go, with in_ready low meanwhile.
//   reset: synchronous, returns the parser to the year field and drops
//   out_valid.
`default_nettype none
module iso_datetime_to_epoch_ns (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic [7:0] char_code,
  input  wire logic last_char,
  output logic out_valid,
  input  wire logic out_ready,
  output logic parse_ok,
  output logic signed [62:0] epoch_ns
);
  import idte_pkg::*;

  cmd_t cmd;
  stat_t stat;

  idte_ctrl u_ctrl (
    .clk, .rst, .in_valid, .last_in(last_char), .in_ready, .out_valid, .out_ready, .cmd
  );
  idte_datapath u_dp (
    .clk, .rst, .c(char_code), .cmd, .stat, .parse_ok_r(parse_ok), .epoch_r(epoch_ns)
  );
endmodule
`default_nettype wire

>>> rtl/idte_checker.sv
// port level checks bound to the top level
`default_nettype none
module idte_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic last_char,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic parse_ok,
  input wire logic signed [62:0] epoch_ns
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(epoch_ns))
    else $error("result dropped while stalled");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !parse_ok |-> epoch_ns == 63'sd0)
    else $error("failed parse with nonzero epoch");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last_char |=> !in_ready)
    else $error("input taken during conversion");
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("valid after reset");
endmodule

bind iso_datetime_to_epoch_ns idte_checker u_chk (.*);
`default_nettype wire

>>> tb/tb_top.sv
// testbench for the iso datetime to epoch nanosecond converter
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import idte_pkg::*;

  typedef struct {
    logic [7:0] code;
    logic       last;
  } char_item_t;

  typedef struct {
    logic               ok;
    logic signed [62:0] ns;
  } epoch_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] char_code = 8'd0;
  logic last_char = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic parse_ok;
  logic signed [62:0] epoch_ns;

  iso_datetime_to_epoch_ns DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .char_code(char_code), .last_char(last_char), .out_valid(out_valid),
    .out_ready(out_ready), .parse_ok(parse_ok), .epoch_ns(epoch_ns)
  );

  always #10 clk = ~clk;

  char_item_t  char_q[$];
  epoch_item_t epoch_q[$];
  int unsigned err_cnt = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_cycles = 0;
  logic        in_ready_seen = 1'b0;

  // parser copy
  phase_t ph;
  int unsigned n_dig, yr, mo, dy, hr, mi, se, fr, fr_n, off_h, off_m;
  bit off_neg, bad;

  task automatic add_char(char_item_t it);
    char_q.insert(char_q.size(), it);
  endtask

  task automatic add_result(epoch_item_t r);
    epoch_q.insert(epoch_q.size(), r);
  endtask

  function automatic bit is_dig(logic [7:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  task automatic clear_parser();
    ph = PH_YEAR;
    n_dig = 0; yr = 0; mo = 0; dy = 0; hr = 0; mi = 0; se = 0;
    fr = 0; fr_n = 0; off_h = 0; off_m = 0; off_neg = 0; bad = 0;
  endtask

  task automatic add_digit(logic [7:0] c, ref int unsigned acc, input int unsigned w,
                           input phase_t nxt);
    if (!is_dig(c)) begin
      bad = 1;
    end else begin
      acc = acc * 10 + (c - CH_0);
      n_dig++;
      if (n_dig >= w) begin
        n_dig = 0;
        ph = nxt;
      end
    end
  endtask

  task automatic zone_char(logic [7:0] c);
    if (c == "Z" || c == "z") ph = PH_DONE;
    else if (c == "+" || c == "-") begin
      off_neg = (c == "-");
      ph = PH_OFF_HOUR;
    end else bad = 1;
  endtask

  task automatic frac_digit(logic [7:0] c);
    if (fr_n < 9) begin
      fr = fr * 10 + (c - CH_0);
      fr_n++;
    end
    ph = PH_FRAC_MORE;
  endtask

  function automatic longint days_since_1970(int unsigned y, int unsigned m, int unsigned d);
    int unsigned yy, era, yoe, mp, doy, doe;
    yy = (m <= 2) ? y - 1 : y;
    era = yy / 400;
    yoe = yy - era * 400;
    mp = (m > 2) ? m - 3 : m + 9;
    doy = (mp * 153 + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return longint'(era) * 146097 + longint'(doe) - 719468;
  endfunction

  function automatic bit fields_in_range();
    int unsigned mx;
    bit leap;
    int unsigned mdays[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    if (yr < 1970 || yr > 2100 || mo < 1 || mo > 12) return 0;
    leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    mx = mdays[mo - 1] + ((mo == 2 && leap) ? 1 : 0);
    if (dy < 1 || dy > mx) return 0;
    if (hr > 23 || mi > 59 || se > 60 || off_h > 23 || off_m > 59) return 0;
    return 1;
  endfunction

  task automatic predict_epoch(char_item_t it);
    logic [7:0] c;
    epoch_item_t r;
    longint frac, off, sec;
    c = it.code;
    if (!bad) begin
      case (ph)
        PH_YEAR:      add_digit(c, yr, 4, PH_DASH1);
        PH_DASH1:     if (c == "-") ph = PH_MONTH; else bad = 1;
        PH_MONTH:     add_digit(c, mo, 2, PH_DASH2);
        PH_DASH2:     if (c == "-") ph = PH_DAY; else bad = 1;
        PH_DAY:       add_digit(c, dy, 2, PH_DATE_END);
        PH_DATE_END:  if (c == "T" || c == " ") ph = PH_HOUR; else bad = 1;
        PH_HOUR:      add_digit(c, hr, 2, PH_COLON);
        PH_COLON:     if (c == ":") ph = PH_MINUTE; else bad = 1;
        PH_MINUTE:    add_digit(c, mi, 2, PH_AFTER_MIN);
        PH_AFTER_MIN: begin
          if (c == ":") ph = PH_SECOND;
          else if (c == ".") ph = PH_FRAC_ONE;
          else zone_char(c);
        end
        PH_SECOND:    add_digit(c, se, 2, PH_AFTER_SEC);
        PH_AFTER_SEC: if (c == ".") ph = PH_FRAC_ONE; else zone_char(c);
        PH_FRAC_ONE:  if (is_dig(c)) frac_digit(c); else bad = 1;
        PH_FRAC_MORE: if (is_dig(c)) frac_digit(c); else zone_char(c);
        PH_OFF_HOUR:  add_digit(c, off_h, 2, PH_OFF_COLON);
        PH_OFF_COLON: if (c == ":") ph = PH_OFF_MIN; else bad = 1;
        PH_OFF_MIN:   add_digit(c, off_m, 2, PH_DONE);
        default:      bad = 1;
      endcase
    end
    if (it.last) begin
      r.ok = !bad && (ph == PH_DATE_END || ph == PH_AFTER_MIN || ph == PH_AFTER_SEC ||
                      ph == PH_FRAC_MORE || ph == PH_DONE) && fields_in_range();
      r.ns = '0;
      if (r.ok) begin
        frac = fr;
        for (int k = fr_n; k < 9; k++) frac = frac * 10;
        off = longint'(off_h) * 3600 + longint'(off_m) * 60;
        if (off_neg) off = -off;
        sec = days_since_1970(yr, mo, dy) * 86400 + longint'(hr) * 3600 +
              longint'(mi) * 60 + longint'(se) - off;
        r.ns = 63'(sec * 1000000000 + frac);
      end
      add_result(r);
      clear_parser();
    end
  endtask

  task automatic queue_text(string s);
    char_item_t it;
    for (int i = 0; i < s.len(); i++) begin
      it.code = s[i];
      it.last = (i == s.len() - 1);
      add_char(it);
    end
  endtask

  function automatic string two_dig(int unsigned v);
    return $sformatf("%0d%0d", v / 10, v % 10);
  endfunction

  // mostly well formed, occasionally out of range
  function automatic string rand_text();
    string s;
    int unsigned y, m, d, nf;
    y = ($urandom_range(0, 9) == 0) ? $urandom_range(1900, 2199) : $urandom_range(1970, 2100);
    m = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
    d = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 31);
    s = $sformatf("%04d-%s-%s", y, two_dig(m), two_dig(d));
    if ($urandom_range(0, 5) == 0) return s;
    s = {s, ($urandom_range(0, 1) ? "T" : " ")};
    s = {s, two_dig($urandom_range(0, 3) == 0 ? $urandom_range(0, 99) : $urandom_range(0, 23))};
    s = {s, ":", two_dig($urandom_range(0, 7) == 0 ? $urandom_range(0, 99)
                                                    : $urandom_range(0, 59))};
    if ($urandom_range(0, 2) != 0)
      s = {s, ":", two_dig($urandom_range(0, 7) == 0 ? $urandom_range(0, 99)
                                                      : $urandom_range(0, 60))};
    if ($urandom_range(0, 1)) begin
      nf = $urandom_range(1, 12);
      s = {s, "."};
      repeat (nf) s = {s, $sformatf("%c", 8'(CH_0 + $urandom_range(0, 9)))};
    end
    case ($urandom_range(0, 4))
      0: ;
      1: s = {s, "Z"};
      2: s = {s, "z"};
      default: s = {s, ($urandom_range(0, 1) ? "+" : "-"),
                    two_dig($urandom_range(0, 4) == 0 ? $urandom_range(0, 99)
                                                       : $urandom_range(0, 23)),
                    ":", two_dig($urandom_range(0, 4) == 0 ? $urandom_range(0, 99)
                                                            : $urandom_range(0, 59))};
    endcase
    return s;
  endfunction

  // corrupt a random text: bad byte, early end or trailing junk
  task automatic queue_broken();
    string s;
    int unsigned n, pos;
    s = rand_text();
    n = s.len();
    case ($urandom_range(0, 2))
      0: begin
        pos = $urandom_range(0, n - 1);
        s[pos] = 8'($urandom_range(0, 255));
      end
      1: s = s.substr(0, $urandom_range(0, n - 2));
      default: s = {s, $sformatf("%c", 8'($urandom_range(1, 255)))};
    endcase
    if (s.len() == 0) s = "9";
    queue_text(s);
  endtask

  task automatic queue_noise(int unsigned n);
    char_item_t it;
    for (int i = 0; i < n; i++) begin
      it.code = 8'($urandom_range(0, 255));
      it.last = (i == n - 1);
      add_char(it);
    end
  endtask

  task automatic drain();
    while (char_q.size() != 0 || in_valid || epoch_q.size() != 0) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || in_ready_seen) begin
        if (char_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          char_code <= char_q[0].code;
          last_char <= char_q[0].last;
          in_valid <= 1'b1;
          predict_epoch(char_q.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (hold_cycles != 0) out_ready <= 1'b0;
      else out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // remembers an accept at the last rising edge for the falling-edge driver
  always @(posedge clk) begin
    in_ready_seen <= in_valid && in_ready;
  end

  // long receiver hold-off countdown
  always @(posedge clk) begin
    if (hold_cycles != 0) hold_cycles <= hold_cycles - 1;
  end

  always @(posedge clk) begin
    epoch_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (epoch_q.size() == 0) begin
        $display("%0t: unexpected result ok=%0b ns=%0d", $time, parse_ok, epoch_ns);
        err_cnt++;
      end else begin
        want = epoch_q.pop_front();
        if (parse_ok !== want.ok || epoch_ns !== want.ns) begin
          $display("%0t: mismatch expected ok=%0b ns=%0d actual ok=%0b ns=%0d",
                   $time, want.ok, want.ns, parse_ok, epoch_ns);
          err_cnt++;
        end
      end
    end
  end

  task automatic random_phase(int unsigned texts);
    repeat (texts) begin
      case ($urandom_range(0, 9))
        0: queue_broken();
        1: queue_noise($urandom_range(1, 6));
        default: queue_text(rand_text());
      endcase
    end
    drain();
  endtask

  initial begin
    clear_parser();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);
    queue_text("1970-01-01");
    queue_text("2100-12-31T23:59:60.999999999Z");
    queue_text("2000-02-29 12:30:15.5+23:59");
    queue_text("1970-01-01T00:00-00:01");
    queue_text("2100-02-29");
    queue_text("1969-12-31T23:59Z");
    queue_text("2024-06-15T08:07:06.1234567891234z");
    queue_text("2024-06-15T08:07Zx");
    queue_text("2024-06");
    queue_text("2024-06-15T24:00");
    queue_text("\xff\x80");
    drain();
    random_phase(8);
    send_idle_pct = 79;
    random_phase(8);
    send_idle_pct = 0;
    recv_stall_pct = 79;
    random_phase(8);
    send_idle_pct = 33;
    recv_stall_pct = 33;
    random_phase(8);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 300;
    random_phase(8);
    send_idle_pct = 10;
    recv_stall_pct = 10;
    random_phase(8);
    repeat (30) @(posedge clk);
    if (err_cnt == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
`default_nettype wire

>>> filelist.f
rtl/idte_pkg.sv
rtl/idte_datapath.sv
rtl/idte_ctrl.sv
rtl/iso_datetime_to_epoch_ns.sv
rtl/idte_checker.sv
tb/tb_top.sv
